// File: rtl/core/cbc_pkg.sv
// Shared widths, register indexes and the frame summary type of the blob centroid block.
package cbc_pkg;

   localparam int CHAN_W      = 8;
   localparam int FWIDTH_W    = 11;
   localparam int RATIO_W     = 4;
   localparam int PROD_W      = CHAN_W + RATIO_W;
   localparam int SUM_W       = 30;
   localparam int HITS_W      = 21;
   localparam int CENT_W      = 10;
   localparam int STEP_W      = $clog2(SUM_W);

   localparam int CSR_AW      = 1;
   localparam int CSR_DW      = FWIDTH_W;
   localparam logic [CSR_AW-1:0] REG_FRAME_WIDTH = 1'd0;
   localparam logic [CSR_AW-1:0] REG_DOM_RATIO   = 1'd1;

   localparam logic [FWIDTH_W-1:0] FRAME_WIDTH_RST = 11'd640;
   localparam logic [RATIO_W-1:0]  DOM_RATIO_RST   = 4'd5;

   localparam int Q_DEPTH     = 4;
   localparam int Q_AW        = $clog2(Q_DEPTH);

   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 48;

   // Accumulated totals of one frame, handed from the front to the divider.
   typedef struct packed {
      logic [SUM_W-1:0]  col_sum;
      logic [SUM_W-1:0]  row_sum;
      logic [HITS_W-1:0] hits;
   } summary_type;

endpackage

// File: rtl/core/cbc_front.sv
// Pixel front end: color test, column and row tracking, saturating accumulation.
module cbc_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [cbc_pkg::FWIDTH_W-1:0]   frame_width,
   input  logic [cbc_pkg::RATIO_W-1:0]    dom_ratio,
   input  logic                           pix_valid,
   output logic                           pix_ready,
   input  logic [cbc_pkg::CHAN_W-1:0]     red,
   input  logic [cbc_pkg::CHAN_W-1:0]     green,
   input  logic [cbc_pkg::CHAN_W-1:0]     blue,
   input  logic                           frame_end,
   input  logic                           q_full,
   output logic                           q_push,
   output cbc_pkg::summary_type           q_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

   logic [COL_W-1:0]          column_ff, column_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic [cbc_pkg::SUM_W-1:0] col_sum_ff, col_sum_in;
   logic [cbc_pkg::SUM_W-1:0] row_sum_ff, row_sum_in;
   logic [cbc_pkg::HITS_W-1:0] hits_ff, hits_in;

   logic [cbc_pkg::PROD_W-1:0] red_scaled, green_scaled;
   logic                       hit;
   logic                       accept;
   logic [cbc_pkg::SUM_W:0]    col_acc, row_acc;
   logic [cbc_pkg::SUM_W-1:0]  col_sum_new, row_sum_new;
   logic [cbc_pkg::HITS_W-1:0] hits_new;
   logic [COL_W:0]             col_next;

   assign pix_ready = !q_full;
   assign accept    = pix_valid && pix_ready;

   assign red_scaled   = cbc_pkg::PROD_W'(dom_ratio) * cbc_pkg::PROD_W'(red);
   assign green_scaled = cbc_pkg::PROD_W'(dom_ratio) * cbc_pkg::PROD_W'(green);
   assign hit = (cbc_pkg::PROD_W'(blue) > red_scaled) &&
                (cbc_pkg::PROD_W'(blue) > green_scaled);

   // A carry out of the 30-bit sum means the sum saturates at all ones.
   assign col_acc = {1'b0, col_sum_ff} + (cbc_pkg::SUM_W + 1)'(column_ff);
   assign row_acc = {1'b0, row_sum_ff} + (cbc_pkg::SUM_W + 1)'(row_ff);

   always_comb begin
      col_sum_new = col_sum_ff;
      row_sum_new = row_sum_ff;
      hits_new    = hits_ff;
      if (hit) begin
         col_sum_new = col_acc[cbc_pkg::SUM_W] ? '1 : col_acc[cbc_pkg::SUM_W-1:0];
         row_sum_new = row_acc[cbc_pkg::SUM_W] ? '1 : row_acc[cbc_pkg::SUM_W-1:0];
         if (hits_ff != '1) begin
            hits_new = hits_ff + 1'b1;
         end
      end
   end

   assign col_next = {1'b0, column_ff} + 1'b1;

   always_comb begin
      column_in  = column_ff;
      row_in     = row_ff;
      col_sum_in = col_sum_ff;
      row_sum_in = row_sum_ff;
      hits_in    = hits_ff;
      if (accept) begin
         if (frame_end) begin
            column_in  = '0;
            row_in     = '0;
            col_sum_in = '0;
            row_sum_in = '0;
            hits_in    = '0;
         end else begin
            col_sum_in = col_sum_new;
            row_sum_in = row_sum_new;
            hits_in    = hits_new;
            if ((32'(col_next) >= 32'(frame_width)) || (32'(col_next) >= MAX_WIDTH)) begin
               column_in = '0;
               if (row_ff != ROW_LAST) begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               column_in = col_next[COL_W-1:0];
            end
         end
      end
   end

   assign q_push          = accept && frame_end;
   assign q_wdata.col_sum = col_sum_new;
   assign q_wdata.row_sum = row_sum_new;
   assign q_wdata.hits    = hits_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff  <= '0;
         row_ff     <= '0;
         col_sum_ff <= '0;
         row_sum_ff <= '0;
         hits_ff    <= '0;
      end else begin
         column_ff  <= column_in;
         row_ff     <= row_in;
         col_sum_ff <= col_sum_in;
         row_sum_ff <= row_sum_in;
         hits_ff    <= hits_in;
      end
   end

endmodule

// File: rtl/core/cbc_queue.sv
// Small queue of frame summaries between the pixel front end and the divider.
module cbc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cbc_pkg::summary_type  wdata,
   input  logic                  pop,
   output cbc_pkg::summary_type  rdata,
   output logic                  full,
   output logic                  empty
);

   cbc_pkg::summary_type        mem_ff [cbc_pkg::Q_DEPTH];
   logic [cbc_pkg::Q_AW-1:0]    wptr_ff, wptr_in;
   logic [cbc_pkg::Q_AW-1:0]    rptr_ff, rptr_in;
   logic [cbc_pkg::Q_AW:0]      count_ff, count_in;
   logic                        do_push, do_pop;

   assign full    = count_ff == (cbc_pkg::Q_AW + 1)'(cbc_pkg::Q_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/core/cbc_back.sv
// Back end: bit-serial restoring division of both sums by the hit count, result register.
module cbc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  cbc_pkg::summary_type          q_rdata,
   output logic                          q_pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_found,
   output logic [cbc_pkg::CENT_W-1:0]    out_cx,
   output logic [cbc_pkg::CENT_W-1:0]    out_cy,
   output logic [cbc_pkg::HITS_W-1:0]    out_hits
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;
   localparam logic [cbc_pkg::STEP_W-1:0] STEP_LAST = cbc_pkg::STEP_W'(cbc_pkg::SUM_W - 1);

   logic [1:0]                    state_ff, state_in;
   logic [cbc_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [cbc_pkg::SUM_W-1:0]     dvx_ff, dvx_in, dvy_ff, dvy_in;
   logic [cbc_pkg::HITS_W-1:0]    remx_ff, remx_in, remy_ff, remy_in;
   logic [cbc_pkg::HITS_W-1:0]    div_ff, div_in;
   logic [cbc_pkg::CENT_W-1:0]    qx_ff, qx_in, qy_ff, qy_in;
   logic                          valid_ff, valid_in;
   logic                          found_ff, found_in;
   logic [cbc_pkg::CENT_W-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [cbc_pkg::HITS_W-1:0]    hits_ff, hits_in;

   logic [cbc_pkg::HITS_W:0]      trial_x, trial_y, div_ext;
   logic                          ge_x, ge_y;
   logic                          load_out;
   logic                          nonzero;

   assign div_ext = {1'b0, div_ff};
   assign trial_x = {remx_ff, dvx_ff[cbc_pkg::SUM_W-1]};
   assign trial_y = {remy_ff, dvy_ff[cbc_pkg::SUM_W-1]};
   assign ge_x    = trial_x >= div_ext;
   assign ge_y    = trial_y >= div_ext;

   assign nonzero  = div_ff != '0;
   assign load_out = (state_ff == ST_FIN) && (!valid_ff || out_ready);
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      dvx_in   = dvx_ff;
      dvy_in   = dvy_ff;
      remx_in  = remx_ff;
      remy_in  = remy_ff;
      div_in   = div_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               dvx_in   = q_rdata.col_sum;
               dvy_in   = q_rdata.row_sum;
               div_in   = q_rdata.hits;
               remx_in  = '0;
               remy_in  = '0;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // The quotient register keeps only its low bits, which is all the output needs.
            remx_in = ge_x ? cbc_pkg::HITS_W'(trial_x - div_ext) : trial_x[cbc_pkg::HITS_W-1:0];
            remy_in = ge_y ? cbc_pkg::HITS_W'(trial_y - div_ext) : trial_y[cbc_pkg::HITS_W-1:0];
            qx_in   = {qx_ff[cbc_pkg::CENT_W-2:0], ge_x};
            qy_in   = {qy_ff[cbc_pkg::CENT_W-2:0], ge_y};
            dvx_in  = dvx_ff << 1;
            dvy_in  = dvy_ff << 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      found_in = found_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      hits_in  = hits_ff;
      if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
      if (load_out) begin
         valid_in = 1'b1;
         found_in = nonzero;
         cx_in    = nonzero ? qx_ff : '0;
         cy_in    = nonzero ? qy_ff : '0;
         hits_in  = div_ff;
      end
   end

   assign out_valid = valid_ff;
   assign out_found = found_ff;
   assign out_cx    = cx_ff;
   assign out_cy    = cy_ff;
   assign out_hits  = hits_ff;

   always_ff @(posedge clock) begin
      dvx_ff  <= dvx_in;
      dvy_ff  <= dvy_in;
      remx_ff <= remx_in;
      remy_ff <= remy_in;
      div_ff  <= div_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      found_ff <= found_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      hits_ff <= hits_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: rtl/core/color_blob_centroid.sv
// Top level of the color blob centroid block: registers, front end, queue and divider.
// The block takes one RGB pixel per clock in raster order and sums column, row and count of
// pixels whose blue exceeds dominance_ratio times red and times green. The pixel with tlast
// closes the frame: its totals go into a four-entry summary queue and the accumulators clear,
// so the next frame starts in the next cycle. A shared restoring divider produces both means
// one quotient bit per cycle; a frame summary is loaded, runs through 30 division steps and
// goes to the result register once that is free. Pixels stall in every cycle in which all
// four queue entries are taken, which happens only when frames end faster than the divider and
// the result receiver retire them. The result carries found, the truncated mean column and row
// (low 10 bits) and the hit count; an empty frame gives zeros. frame_width and dominance_ratio
// reset to 640 and 5 and should be written only while no frame is in progress.
module color_blob_centroid #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cbc_pkg::REQ_DATA_W-1:0]    req_tdata,   // red, green, blue
   input  logic                              req_tlast,   // frame_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cbc_pkg::RSP_DATA_W-1:0]    rsp_tdata, // found, centroid_x, centroid_y, hit_count
   input  logic                              csr_we,
   input  logic [cbc_pkg::CSR_AW-1:0]        csr_addr,
   input  logic [cbc_pkg::CSR_DW-1:0]        csr_wdata
);

   logic [cbc_pkg::FWIDTH_W-1:0] frame_width_ff, frame_width_in;
   logic [cbc_pkg::RATIO_W-1:0]  dom_ratio_ff, dom_ratio_in;

   logic                         q_full, q_empty, q_push, q_pop;
   cbc_pkg::summary_type         q_wdata, q_rdata;

   logic                         out_found;
   logic [cbc_pkg::CENT_W-1:0]   out_cx, out_cy;
   logic [cbc_pkg::HITS_W-1:0]   out_hits;

   always_comb begin
      frame_width_in = frame_width_ff;
      dom_ratio_in   = dom_ratio_ff;
      if (csr_we) begin
         case (csr_addr)
            cbc_pkg::REG_FRAME_WIDTH: frame_width_in = csr_wdata[cbc_pkg::FWIDTH_W-1:0];
            cbc_pkg::REG_DOM_RATIO:   dom_ratio_in   = csr_wdata[cbc_pkg::RATIO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= cbc_pkg::FRAME_WIDTH_RST;
         dom_ratio_ff   <= cbc_pkg::DOM_RATIO_RST;
      end else begin
         frame_width_ff <= frame_width_in;
         dom_ratio_ff   <= dom_ratio_in;
      end
   end

   cbc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .frame_width (frame_width_ff),
      .dom_ratio   (dom_ratio_ff),
      .pix_valid   (req_tvalid),
      .pix_ready   (req_tready),
      .red         (req_tdata[7:0]),
      .green       (req_tdata[15:8]),
      .blue        (req_tdata[23:16]),
      .frame_end   (req_tlast),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_wdata     (q_wdata)
   );

   cbc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   cbc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_found (out_found),
      .out_cx    (out_cx),
      .out_cy    (out_cy),
      .out_hits  (out_hits)
   );

   assign rsp_tdata = {6'd0, out_hits, out_cy, out_cx, out_found};

endmodule

// File: rtl/core/cbc_checker.sv
// Port-level checks on the color blob centroid block, bound to the top level.
module cbc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [cbc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic                        found;
   logic [cbc_pkg::CENT_W-1:0]  cx, cy;
   logic [cbc_pkg::HITS_W-1:0]  hits;

   assign found = rsp_tdata[0];
   assign cx    = rsp_tdata[10:1];
   assign cy    = rsp_tdata[20:11];
   assign hits  = rsp_tdata[41:21];

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_found_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (found == (hits != '0)))
      else $error("found does not match hit count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !found |-> (cx == '0) && (cy == '0))
      else $error("empty frame with nonzero centroid");

   // Reset clears the result valid register, so no result can follow reset directly.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

endmodule

bind color_blob_centroid cbc_checker u_cbc_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for color_blob_centroid: pixel stimulus, frame predictor and checks.
module testbench;

   localparam int PIX_MAX_WIDTH  = 1024;
   localparam int PIX_MAX_HEIGHT = 1024;
   localparam longint unsigned SUM_LIMIT  = (64'd1 << cbc_pkg::SUM_W) - 1;
   localparam int unsigned     HITS_LIMIT = (32'd1 << cbc_pkg::HITS_W) - 1;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 40;

   // One frame summary as it sits in rsp_tdata, found in the lowest bit.
   typedef struct packed {
      logic [cbc_pkg::HITS_W-1:0] hit_count;
      logic [cbc_pkg::CENT_W-1:0] centroid_y;
      logic [cbc_pkg::CENT_W-1:0] centroid_x;
      logic                       found;
   } blob_result_type;

   class blob_scoreboard;
      logic [cbc_pkg::FWIDTH_W-1:0] frame_width;
      logic [cbc_pkg::RATIO_W-1:0]  dom_ratio;
      int unsigned                  column;
      int unsigned                  row;
      int unsigned                  hits;
      longint unsigned              column_sum;
      longint unsigned              row_sum;
      blob_result_type              frames_due[$];
      int                           errors;

      function new();
         errors = 0;
         frame_width = cbc_pkg::FRAME_WIDTH_RST;
         dom_ratio = cbc_pkg::DOM_RATIO_RST;
         clear_frame();
      endfunction

      function void clear_frame();
         column = 0;
         row = 0;
         hits = 0;
         column_sum = 0;
         row_sum = 0;
      endfunction

      function void write_reg(logic [cbc_pkg::CSR_AW-1:0] idx,
                              logic [cbc_pkg::CSR_DW-1:0] value);
         if (idx == cbc_pkg::REG_FRAME_WIDTH) begin
            frame_width = value;
         end else if (idx == cbc_pkg::REG_DOM_RATIO) begin
            dom_ratio = value[cbc_pkg::RATIO_W-1:0];
         end
      endfunction

      function int pending();
         return frames_due.size();
      endfunction

      function void note_pixel(logic [cbc_pkg::REQ_DATA_W-1:0] data, logic last);
         int unsigned     r, g, b, next_col;
         longint unsigned qx, qy;
         blob_result_type res;
         r = data[7:0];
         g = data[15:8];
         b = data[23:16];
         if (b > dom_ratio * r && b > dom_ratio * g) begin
            column_sum = column_sum + column;
            if (column_sum > SUM_LIMIT) column_sum = SUM_LIMIT;
            row_sum = row_sum + row;
            if (row_sum > SUM_LIMIT) row_sum = SUM_LIMIT;
            if (hits < HITS_LIMIT) hits++;
         end
         if (last) begin
            qx = 0;
            qy = 0;
            if (hits > 0) begin
               qx = column_sum / hits;
               qy = row_sum / hits;
            end
            res.found = (hits > 0);
            res.centroid_x = qx[cbc_pkg::CENT_W-1:0];
            res.centroid_y = qy[cbc_pkg::CENT_W-1:0];
            res.hit_count = hits[cbc_pkg::HITS_W-1:0];
            frames_due.push_back(res);
            clear_frame();
            return;
         end
         next_col = column + 1;
         if (next_col >= frame_width || next_col >= PIX_MAX_WIDTH) begin
            column = 0;
            if (row + 1 < PIX_MAX_HEIGHT) row++;
         end else begin
            column = next_col;
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [cbc_pkg::RSP_DATA_W-1:0] data);
         blob_result_type got, want;
         got = data[$bits(blob_result_type)-1:0];
         if (frames_due.size() == 0) begin
            $error("frame result arrived with no frame outstanding");
            errors++;
            return;
         end
         want = frames_due.pop_front();
         compare_field("found", want.found, got.found);
         compare_field("centroid_x", want.centroid_x, got.centroid_x);
         compare_field("centroid_y", want.centroid_y, got.centroid_y);
         compare_field("hit_count", want.hit_count, got.hit_count);
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [cbc_pkg::REQ_DATA_W-1:0] req_tdata;   // red, green, blue
   logic                           req_tlast;   // frame_end
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [cbc_pkg::RSP_DATA_W-1:0] rsp_tdata;   // found, centroid_x, centroid_y, hit_count
   logic                           csr_we;
   logic [cbc_pkg::CSR_AW-1:0]     csr_addr;
   logic [cbc_pkg::CSR_DW-1:0]     csr_wdata;

   blob_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   int stall_count = 0;

   color_blob_centroid uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_pixel(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count = 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("color_blob_centroid: mismatch");
         $finish;
      end else begin
         stall_count++;
      end
   end

   // A long hold-off takes priority over the random backpressure.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_pixel(input logic [7:0] r, g, b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b, g, r};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic draw_pixel(output logic [7:0] r, g, b);
      int k, dom, bv, rv, gv;
      k = $urandom_range(9);
      dom = sb.dom_ratio;
      bv = $urandom_range(255);
      rv = $urandom_range(255);
      gv = $urandom_range(255);
      if (k >= 4 && k <= 7) begin
         // Mostly passing pixels.
         rv = $urandom_range(0, bv / (dom + 1));
         gv = $urandom_range(0, bv / (dom + 1));
      end else if (k == 8) begin
         rv = $urandom_range(1) * 255;
         gv = $urandom_range(1) * 255;
         bv = $urandom_range(1) * 255;
      end else if (k == 9) begin
         // Right at the dominance threshold.
         rv = (dom == 0) ? $urandom_range(1) : bv / dom;
         gv = (rv > 0) ? rv - $urandom_range(1) : 0;
      end
      r = 8'(rv);
      g = 8'(gv);
      b = 8'(bv);
   endtask

   task automatic send_frame(input int len);
      logic [7:0] r, g, b;
      for (int i = 0; i < len; i++) begin
         draw_pixel(r, g, b);
         send_pixel(r, g, b, i == len - 1);
      end
   endtask

   // Registers change only with no frame open and every result collected.
   task automatic reconfigure(input int fw, input int ratio);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= cbc_pkg::REG_FRAME_WIDTH;
      csr_wdata <= cbc_pkg::CSR_DW'(fw);
      sb.write_reg(cbc_pkg::REG_FRAME_WIDTH, cbc_pkg::CSR_DW'(fw));
      @(negedge clock);
      csr_addr <= cbc_pkg::REG_DOM_RATIO;
      csr_wdata <= cbc_pkg::CSR_DW'(ratio);
      sb.write_reg(cbc_pkg::REG_DOM_RATIO, cbc_pkg::CSR_DW'(ratio));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int pixels_sent, len, fw, k;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_we <= 1'b0;
      csr_addr <= cbc_pkg::REG_FRAME_WIDTH;
      csr_wdata <= '0;
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: an empty frame, then values around the ratio boundary.
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd51, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd50, 8'd50, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd51, 8'd255, 1'b1);
      // Zero width keeps the column at zero; zero ratio only needs blue above zero.
      reconfigure(0, 0);
      send_pixel(8'd255, 8'd255, 8'd1, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd1, 1'b1);
      reconfigure(1024, 15);
      send_pixel(8'd17, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd16, 8'd16, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd17, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
      reconfigure(2047, 1);
      send_pixel(8'd254, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd254, 8'd255, 1'b1);
      reconfigure(1, 1);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd1, 8'd0, 8'd2, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd0, 1'b1);

      // Short frames against a stalled receiver fill the summary queue.
      reconfigure(3, 5);
      @(posedge clock);
      hold_left = 400;
      @(negedge clock);
      for (int i = 0; i < 80; i++) send_frame(2);

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 9 : (mode == 1) ? 83 : 0;
         recv_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 9 : 0;
         pixels_sent = 0;
         while (pixels_sent < 230) begin
            if ($urandom_range(7) == 0) begin
               k = $urandom_range(9);
               fw = (k == 0) ? 0 : (k == 1) ? 1024 : (k == 2) ? 2047 :
                    (k == 3) ? $urandom_range(2047) : $urandom_range(1, 16);
               reconfigure(fw, $urandom_range(15));
            end
            k = $urandom_range(15);
            len = (k == 0) ? 1 : (k == 1) ? $urandom_range(60, 200) : $urandom_range(1, 24);
            send_frame(len);
            pixels_sent += len;
         end
      end

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (sb.errors == 0) begin
         $display("color_blob_centroid: match");
      end else begin
         $display("color_blob_centroid: mismatch");
      end
      $finish;
   end

endmodule
